// ===== rtl/rtpx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTP extension packet checker package
// Shared sizes, protocol constants and the types passed between stages.
// ----------------------------------------------------------------------------
package rtpx_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 2048;
  localparam int unsigned HEADER_BYTES     = 24;
  localparam int unsigned TRAILER_BYTES    = 4;

  // Byte counter saturates at MAX_PACKET_BYTES + 1
  localparam int unsigned CNT_W  = $clog2(MAX_PACKET_BYTES + 2);
  localparam int unsigned PLEN_W = 11;

  localparam logic [CNT_W-1:0] OVF_CNT = CNT_W'(MAX_PACKET_BYTES + 1);

  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [15:0] EXT_WORDS   = 16'd2;
  localparam logic [1:0]  RTP_VERSION = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } rtpx_beat_t;

  typedef struct packed {
    logic              status;
    logic              crc_valid;
    logic [PLEN_W-1:0] payload_length;
    logic [6:0]        payload_kind;
    logic              marker;
    logic [3:0]        csrc_count;
    logic [15:0]       seq_number;
    logic [31:0]       rtp_time;
    logic [31:0]       source_id;
    logic [15:0]       stream_number;
    logic [15:0]       seq_extension;
    logic [31:0]       media_time;
  } rtpx_result_t;

endpackage
`default_nettype wire

// ===== rtl/rtpx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTP extension packet checker channels
// Valid/ready byte input channel and per-packet result channel.
// ----------------------------------------------------------------------------
interface rtpx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rtpx_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        crc_valid;
  logic [10:0] payload_length;
  logic [6:0]  payload_kind;
  logic        marker;
  logic [3:0]  csrc_count;
  logic [15:0] seq_number;
  logic [31:0] rtp_time;
  logic [31:0] source_id;
  logic [15:0] stream_number;
  logic [15:0] seq_extension;
  logic [31:0] media_time;

  modport source (
    output valid, input ready,
    output status, output crc_valid, output payload_length, output payload_kind,
    output marker, output csrc_count, output seq_number, output rtp_time,
    output source_id, output stream_number, output seq_extension, output media_time
  );
  modport sink (
    input valid, output ready,
    input status, input crc_valid, input payload_length, input payload_kind,
    input marker, input csrc_count, input seq_number, input rtp_time,
    input source_id, input stream_number, input seq_extension, input media_time
  );
endinterface
`default_nettype wire

// ===== rtl/rtp_ext_packet_checker_crc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle when no Stall holds it; the byte-wide unrolled
//   CRC-32 update sets the cycle. Path: a byte is registered at its transfer, then
//   folded into the packet state; a last byte's result goes to the result register.
// Stall: a last byte waits in the input register while a held result is not taken.
// Reset: rst_n is synchronous and active low; it clears the packet state,
//   sets profile_r to zero and empties both registers.
// ----------------------------------------------------------------------------
// RTP extension packet checker with CRC-32 trailer
// Parses a 24-byte RTP + extension + stream header from a byte stream,
// checks it, and detects a big-endian CRC-32 trailer at the end of the data.
// ----------------------------------------------------------------------------
module rtp_ext_packet_checker_crc_core (
  input  logic              clk,
  input  logic              rst_n,
  rtpx_in_if.sink           in_chan,
  rtpx_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  rtpx_pkg::rtpx_beat_t   in_beat;
  rtpx_pkg::rtpx_beat_t   beat;
  rtpx_pkg::rtpx_result_t res_next;
  rtpx_pkg::rtpx_result_t res;
  logic                   beat_adv;
  logic                   res_load;
  logic                   out_free;
  logic                   out_vld;

  assign in_beat.data_byte = in_chan.data_byte;
  assign in_beat.last      = in_chan.last;

  // Input register: take a byte when empty or when the held one advances this cycle
  rtpx_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_beat  (in_beat),
    .out_free (out_free),
    .beat_adv (beat_adv),
    .beat     (beat)
  );

  // Packet state: count, capture header, run trailer delay line and CRC
  rtpx_pkt_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .beat_adv  (beat_adv),
    .beat      (beat),
    .res_load  (res_load),
    .res       (res_next)
  );

  // Result register: parts the result side from the byte side
  rtpx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_in    (res_next),
    .out_ready (out_chan.ready),
    .out_valid (out_vld),
    .out_free  (out_free),
    .res_out   (res)
  );

  // Drive the result transfer fields from the held result
  assign out_chan.valid          = out_vld;
  assign out_chan.status         = res.status;
  assign out_chan.crc_valid      = res.crc_valid;
  assign out_chan.payload_length = res.payload_length;
  assign out_chan.payload_kind   = res.payload_kind;
  assign out_chan.marker         = res.marker;
  assign out_chan.csrc_count     = res.csrc_count;
  assign out_chan.seq_number     = res.seq_number;
  assign out_chan.rtp_time       = res.rtp_time;
  assign out_chan.source_id      = res.source_id;
  assign out_chan.stream_number  = res.stream_number;
  assign out_chan.seq_extension  = res.seq_extension;
  assign out_chan.media_time     = res.media_time;

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded over a pending result");

  a_crc_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> !(res.crc_valid && res.status))
    else $error("crc_valid on a rejected packet");

  a_reject_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && res.status) |-> (res.payload_length == '0))
    else $error("rejected packet reports payload");

endmodule
`default_nettype wire

// ===== rtl/rtpx_crc_byte.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTP extension CRC byte update
// Reflected CRC-32 advanced by one byte, unrolled over its eight bits.
// ----------------------------------------------------------------------------
module rtpx_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_byte,
  output logic [31:0] crc_out
);

  logic [31:0] crc_work;

  always_comb begin
    crc_work = crc_in ^ {24'd0, data_byte};
    for (int k = 0; k < 8; k++) begin
      crc_work = crc_work[0] ? ((crc_work >> 1) ^ rtpx_pkg::CRC_POLY) : (crc_work >> 1);
    end
    crc_out = crc_work;
  end

endmodule
`default_nettype wire

// ===== rtl/rtpx_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTP extension input register
// Holds one accepted byte until the packet state takes it.
// ----------------------------------------------------------------------------
module rtpx_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtpx_pkg::rtpx_beat_t in_beat,
  input  logic                out_free,
  output logic                beat_adv,
  output rtpx_pkg::rtpx_beat_t beat
);

  logic                 vld_r;
  rtpx_pkg::rtpx_beat_t beat_r;

  // A last byte needs room in the result register; other bytes always advance
  assign beat_adv = vld_r && (!beat_r.last || out_free);
  assign in_ready = !vld_r || beat_adv;
  assign beat     = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rtpx_pkt_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTP extension packet state
// Byte count, header capture, trailer delay line and CRC; builds the result.
// ----------------------------------------------------------------------------
module rtpx_pkt_state (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  input  logic                   beat_adv,
  input  rtpx_pkg::rtpx_beat_t   beat,
  output logic                   res_load,
  output rtpx_pkg::rtpx_result_t res
);

  localparam int unsigned CW = rtpx_pkg::CNT_W;
  localparam int unsigned HB = rtpx_pkg::HEADER_BYTES;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    hdr_r   [HB];
  logic [7:0]    hdr_nxt [HB];
  logic [31:0]   crc_r, crc_nxt, crc_step;
  logic [31:0]   tail_r, tail_nxt;
  logic          ovf_r, ovf_nxt;
  logic [15:0]   profile_r;

  logic          reject;
  logic          crc_ok;
  logic [CW-1:0] data_cnt;
  logic [CW-1:0] plen;

  rtpx_crc_byte u_crc (
    .crc_in    (crc_r),
    .data_byte (tail_r[31:24]),
    .crc_out   (crc_step)
  );

  always_comb begin
    cnt_nxt  = cnt_r;
    hdr_nxt  = hdr_r;
    crc_nxt  = crc_r;
    tail_nxt = tail_r;
    ovf_nxt  = ovf_r;
    if (beat_adv && !ovf_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_nxt > CW'(rtpx_pkg::MAX_PACKET_BYTES)) begin
        ovf_nxt = 1'b1;
      end else if (cnt_r < CW'(HB)) begin
        for (int i = 0; i < HB; i++) begin
          if (cnt_r == CW'(i)) begin
            hdr_nxt[i] = beat.data_byte;
          end
        end
      end else begin
        // Feed the byte leaving the delay line once four data bytes are held
        if (cnt_r >= CW'(HB + rtpx_pkg::TRAILER_BYTES)) begin
          crc_nxt = crc_step;
        end
        tail_nxt = {tail_r[23:0], beat.data_byte};
      end
    end
  end

  assign res_load = beat_adv && beat.last;

  always_comb begin
    reject = ovf_nxt
          || (cnt_nxt < CW'(HB))
          || (hdr_nxt[0][7:6] != rtpx_pkg::RTP_VERSION)
          || !hdr_nxt[0][4]
          || ({hdr_nxt[12], hdr_nxt[13]} != profile_r)
          || ({hdr_nxt[14], hdr_nxt[15]} != rtpx_pkg::EXT_WORDS);
    data_cnt = cnt_nxt - CW'(HB);
    crc_ok   = !reject
            && (data_cnt >= CW'(rtpx_pkg::TRAILER_BYTES))
            && (data_cnt[1:0] == 2'd0)
            && ((crc_nxt ^ rtpx_pkg::CRC_INIT) == tail_nxt);
    if (reject) begin
      plen = '0;
    end else if (crc_ok) begin
      plen = data_cnt - CW'(rtpx_pkg::TRAILER_BYTES);
    end else begin
      plen = data_cnt;
    end

    res.status         = reject;
    res.crc_valid      = crc_ok;
    res.payload_length = plen[rtpx_pkg::PLEN_W-1:0];
    res.payload_kind   = hdr_nxt[1][6:0];
    res.marker         = hdr_nxt[1][7];
    res.csrc_count     = hdr_nxt[0][3:0];
    res.seq_number     = {hdr_nxt[2], hdr_nxt[3]};
    res.rtp_time       = {hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7]};
    res.source_id      = {hdr_nxt[8], hdr_nxt[9], hdr_nxt[10], hdr_nxt[11]};
    res.stream_number  = {hdr_nxt[16], hdr_nxt[17]};
    res.seq_extension  = {hdr_nxt[18], hdr_nxt[19]};
    res.media_time     = {hdr_nxt[20], hdr_nxt[21], hdr_nxt[22], hdr_nxt[23]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= '0;
    end else if (cfg_we) begin
      profile_r <= cfg_wdata;
    end
  end

  // Drop all packet state after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      cnt_r  <= '0;
      crc_r  <= rtpx_pkg::CRC_INIT;
      tail_r <= '0;
      ovf_r  <= 1'b0;
      for (int i = 0; i < HB; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
      tail_r <= tail_nxt;
      ovf_r  <= ovf_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == rtpx_pkg::OVF_CNT))
    else $error("oversize flag set without saturated count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (cnt_r == '0) && !ovf_r && (crc_r == rtpx_pkg::CRC_INIT))
    else $error("packet state not cleared after last byte");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rtpx_pkg::OVF_CNT)
    else $error("byte count beyond saturation");

endmodule
`default_nettype wire

// ===== rtl/rtpx_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTP extension result register
// Holds one packet result until the output transfer completes.
// ----------------------------------------------------------------------------
module rtpx_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_load,
  input  rtpx_pkg::rtpx_result_t res_in,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_free,
  output rtpx_pkg::rtpx_result_t res_out
);

  logic                   vld_r;
  rtpx_pkg::rtpx_result_t res_r;

  assign out_free  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_in;
    end
  end

endmodule
`default_nettype wire

// ===== bench/rtpx_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP extension packet checker - result scoreboard
// Follows the byte stream into the parser, predicts the per-packet result,
// and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rtpx_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  rtpx_in_if          in_mon,
  rtpx_out_if         out_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);

  logic [15:0]            profile_sel;
  logic [11:0]            byte_cnt;
  logic [7:0]             hdr_bytes [rtpx_pkg::HEADER_BYTES];
  logic [31:0]            crc_acc;
  logic [31:0]            tail_word;
  logic                   over_limit;
  rtpx_pkg::rtpx_result_t expected_q [$];

  function automatic logic [31:0] fold_crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = (c >> 1) ^ (c[0] ? rtpx_pkg::CRC_POLY : 32'd0);
    return c;
  endfunction

  task automatic clear_packet();
    byte_cnt   = '0;
    crc_acc    = rtpx_pkg::CRC_INIT;
    tail_word  = '0;
    over_limit = 1'b0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
  endtask

  // Advance the parser by one byte; on the last byte queue the packet result.
  task automatic absorb_byte(input logic [7:0] b, input logic is_last);
    logic [11:0]            idx;
    logic [11:0]            data_cnt;
    logic                   reject;
    rtpx_pkg::rtpx_result_t r;
    if (!over_limit) begin
      idx      = byte_cnt;
      byte_cnt = byte_cnt + 12'd1;
      if (byte_cnt > rtpx_pkg::MAX_PACKET_BYTES) begin
        over_limit = 1'b1;
      end else if (idx < rtpx_pkg::HEADER_BYTES) begin
        hdr_bytes[idx] = b;
      end else begin
        // delay line: a byte is folded into the CRC once four more follow it
        if (idx - rtpx_pkg::HEADER_BYTES >= rtpx_pkg::TRAILER_BYTES)
          crc_acc = fold_crc_byte(crc_acc, tail_word[31:24]);
        tail_word = {tail_word[23:0], b};
      end
    end
    if (is_last) begin
      reject = over_limit
            || byte_cnt < rtpx_pkg::HEADER_BYTES
            || hdr_bytes[0][7:6] != rtpx_pkg::RTP_VERSION
            || !hdr_bytes[0][4]
            || {hdr_bytes[12], hdr_bytes[13]} != profile_sel
            || {hdr_bytes[14], hdr_bytes[15]} != rtpx_pkg::EXT_WORDS;
      r = '0;
      r.status = reject;
      if (!reject) begin
        data_cnt         = byte_cnt - 12'(rtpx_pkg::HEADER_BYTES);
        r.payload_length = data_cnt[10:0];
        if (data_cnt >= rtpx_pkg::TRAILER_BYTES && data_cnt[1:0] == 2'd0
            && (crc_acc ^ rtpx_pkg::CRC_INIT) == tail_word) begin
          r.crc_valid      = 1'b1;
          r.payload_length = 11'(data_cnt - 12'(rtpx_pkg::TRAILER_BYTES));
        end
      end
      r.payload_kind  = hdr_bytes[1][6:0];
      r.marker        = hdr_bytes[1][7];
      r.csrc_count    = hdr_bytes[0][3:0];
      r.seq_number    = {hdr_bytes[2], hdr_bytes[3]};
      r.rtp_time      = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
      r.source_id     = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
      r.stream_number = {hdr_bytes[16], hdr_bytes[17]};
      r.seq_extension = {hdr_bytes[18], hdr_bytes[19]};
      r.media_time    = {hdr_bytes[20], hdr_bytes[21], hdr_bytes[22], hdr_bytes[23]};
      expected_q.push_back(r);
      clear_packet();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatch_count = mismatch_count + 1;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rtpx_pkg::rtpx_result_t want;
    if (!rst_n) begin
      profile_sel = '0;
      clear_packet();
      expected_q.delete();
    end else begin
      if (cfg_we) profile_sel = cfg_wdata;
      if (in_mon.valid && in_mon.ready) absorb_byte(in_mon.data_byte, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: result transfer with none expected: expected nothing, actual status %0b",
                   $time, out_mon.status);
        end else begin
          want = expected_q.pop_front();
          check_field("status",         want.status,         out_mon.status);
          check_field("crc_valid",      want.crc_valid,      out_mon.crc_valid);
          check_field("payload_length", want.payload_length, out_mon.payload_length);
          check_field("payload_kind",   want.payload_kind,   out_mon.payload_kind);
          check_field("marker",         want.marker,         out_mon.marker);
          check_field("csrc_count",     want.csrc_count,     out_mon.csrc_count);
          check_field("seq_number",     want.seq_number,     out_mon.seq_number);
          check_field("rtp_time",       want.rtp_time,       out_mon.rtp_time);
          check_field("source_id",      want.source_id,      out_mon.source_id);
          check_field("stream_number",  want.stream_number,  out_mon.stream_number);
          check_field("seq_extension",  want.seq_extension,  out_mon.seq_extension);
          check_field("media_time",     want.media_time,     out_mon.media_time);
        end
      end
    end
    results_pending = expected_q.size();
  end

endmodule

// ===== bench/rtp_ext_packet_checker_crc_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP extension packet checker - testbench top
// Drives byte packets into the checker core with random gaps and back
// pressure, steps the profile register through several values, and leaves
// all prediction and comparison to the scoreboard beside the core.
// ----------------------------------------------------------------------------
module rtp_ext_packet_checker_crc_core_test;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SETTLE_CYCLES  = 8;     // idle margin after a drain
  localparam int unsigned CHOKE_CYCLES   = 400;   // long receiver hold-off
  localparam int unsigned RANDOM_BYTES   = 500;
  localparam int unsigned RANDOM_RESULTS = 12;
  localparam int unsigned RANDOM_PHASES  = 3;
  localparam int unsigned WHOLE          = 0;     // send the full packet, no truncation

  typedef enum int { TRAILER_NONE, TRAILER_GOOD, TRAILER_BAD } trailer_t;
  typedef enum int { BAD_VERSION, NO_EXT_BIT, WRONG_PROFILE, WRONG_EXT_LEN } defect_t;

  // 24-byte header in wire order, first byte in the top bits
  typedef struct packed {
    logic [1:0]  ver;
    logic        pad;
    logic        ext;
    logic [3:0]  cc;
    logic        mark;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [15:0] profile;
    logic [15:0] ext_len;
    logic [15:0] stream;
    logic [15:0] seq_ext;
    logic [31:0] media;
  } rtp_hdr_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic [15:0] cur_profile = '0;
  logic        sender_calm = 1'b0;

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned bytes_sent   = 0;
  int unsigned packets_sent = 0;
  int unsigned choke_asked  = 0;
  int unsigned choke_served = 0;

  rtpx_in_if  in_chan ();
  rtpx_out_if out_chan ();

  rtp_ext_packet_checker_crc_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rtpx_result_checker u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatches),
    .results_pending (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap or a short one; now and then a long one.
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic rtp_hdr_t random_header();
    rtp_hdr_t h;
    h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return h;
  endfunction

  // Random content, but the fields the core checks are all set to pass.
  function automatic rtp_hdr_t good_header();
    rtp_hdr_t h;
    h         = random_header();
    h.ver     = rtpx_pkg::RTP_VERSION;
    h.ext     = 1'b1;
    h.profile = cur_profile;
    h.ext_len = rtpx_pkg::EXT_WORDS;
    return h;
  endfunction

  function automatic rtp_hdr_t break_header(input rtp_hdr_t h, input defect_t d);
    logic [15:0] flip;
    flip = 16'($urandom_range(1, 16'hFFFF));
    unique case (d)
      BAD_VERSION:   h.ver     = h.ver + 2'($urandom_range(1, 3));
      NO_EXT_BIT:    h.ext     = 1'b0;
      WRONG_PROFILE: h.profile = h.profile ^ flip;
      WRONG_EXT_LEN: h.ext_len = h.ext_len ^ flip;
    endcase
    return h;
  endfunction

  function automatic trailer_t pick_trailer();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return TRAILER_GOOD;
    if (r < 65) return TRAILER_BAD;
    return TRAILER_NONE;
  endfunction

  // Mostly short data, usually word aligned so a trailer can be found.
  function automatic int unsigned pick_body();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(100, 600);
    if (r < 70) return 4 * $urandom_range(0, 10);
    return $urandom_range(0, 40);
  endfunction

  // Build header, random data and optional CRC-32 trailer, then transfer the
  // first 'keep' bytes (or all of them) with last on the final one sent.
  task automatic send_packet(input rtp_hdr_t h, input int unsigned body_len,
                             input trailer_t tr, input int unsigned keep);
    logic [7:0]   pkt [$];
    logic [191:0] flat;
    logic [31:0]  crc;
    logic [31:0]  flip;
    logic [7:0]   b;
    int unsigned  n;
    int unsigned  i;
    int unsigned  gap;
    flat = h;
    crc  = rtpx_pkg::CRC_INIT;
    for (i = 0; i < rtpx_pkg::HEADER_BYTES; i++) pkt.push_back(flat[191 - 8 * i -: 8]);
    for (i = 0; i < body_len; i++) begin
      b   = 8'($urandom);
      crc = crc ^ {24'd0, b};
      repeat (8) crc = (crc >> 1) ^ (crc[0] ? rtpx_pkg::CRC_POLY : 32'd0);
      pkt.push_back(b);
    end
    crc = crc ^ rtpx_pkg::CRC_INIT;
    if (tr == TRAILER_BAD) begin
      // corrupt the trailer by a nonzero pattern so it can never match
      flip = $urandom;
      if (flip == 0) flip = 32'h1;
      crc = crc ^ flip;
    end
    if (tr != TRAILER_NONE) begin
      for (i = 0; i < 4; i++) pkt.push_back(crc[31 - 8 * i -: 8]);
    end
    n = (keep == WHOLE) ? pkt.size() : keep;
    sender_calm = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      gap = pick_gap(sender_calm);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_chan.valid     <= 1'b1;
      in_chan.data_byte <= pkt[i];
      in_chan.last      <= (i == n - 1);
      // hold the byte until the core takes it
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    packets_sent++;
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  // Only touch the register while the core is idle.
  task automatic write_profile(input logic [15:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    cur_profile  = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    rtp_hdr_t h;
    // header extremes: every reported field at its maximum, then at zero
    h         = '1;
    h.ver     = rtpx_pkg::RTP_VERSION;
    h.profile = cur_profile;
    h.ext_len = rtpx_pkg::EXT_WORDS;
    send_packet(h, 0, TRAILER_NONE, WHOLE);
    h         = '0;
    h.ver     = rtpx_pkg::RTP_VERSION;
    h.ext     = 1'b1;
    h.profile = cur_profile;
    h.ext_len = rtpx_pkg::EXT_WORDS;
    send_packet(h, 0, TRAILER_GOOD, WHOLE);   // trailer alone, CRC of no data
    // trailer detection around the word boundary
    send_packet(good_header(), 0, TRAILER_BAD, WHOLE);
    send_packet(good_header(), 3, TRAILER_NONE, WHOLE);
    send_packet(good_header(), 4, TRAILER_GOOD, WHOLE);
    send_packet(good_header(), 5, TRAILER_GOOD, WHOLE);
    send_packet(good_header(), 6, TRAILER_NONE, WHOLE);
    send_packet(good_header(), 8, TRAILER_BAD, WHOLE);
    // too short: one byte, and one byte shy of a full header
    send_packet(good_header(), 0, TRAILER_NONE, 1);
    send_packet(good_header(), 0, TRAILER_NONE, rtpx_pkg::HEADER_BYTES - 1);
    // each header defect
    send_packet(break_header(good_header(), BAD_VERSION), 4, TRAILER_GOOD, WHOLE);
    send_packet(break_header(good_header(), NO_EXT_BIT), 4, TRAILER_GOOD, WHOLE);
    send_packet(break_header(good_header(), WRONG_PROFILE), 4, TRAILER_GOOD, WHOLE);
    send_packet(break_header(good_header(), WRONG_EXT_LEN), 4, TRAILER_GOOD, WHOLE);
    // size limit: exactly at the maximum, and one over
    send_packet(good_header(), rtpx_pkg::MAX_PACKET_BYTES - rtpx_pkg::HEADER_BYTES - 4,
                TRAILER_GOOD, WHOLE);
    send_packet(good_header(), rtpx_pkg::MAX_PACKET_BYTES - rtpx_pkg::HEADER_BYTES + 1,
                TRAILER_NONE, WHOLE);
  endtask

  // Mostly well-formed packets with random content; the rest broken
  // headers, truncated packets and pure noise.
  task automatic run_random(input int unsigned byte_goal, input int unsigned result_goal);
    int unsigned start_bytes;
    int unsigned start_pkts;
    int unsigned r;
    start_bytes = bytes_sent;
    start_pkts  = packets_sent;
    while (bytes_sent - start_bytes < byte_goal || packets_sent - start_pkts < result_goal) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_packet(good_header(), pick_body(), pick_trailer(), WHOLE);
      end else if (r < 80) begin
        send_packet(break_header(good_header(), defect_t'($urandom_range(0, 3))),
                    pick_body(), pick_trailer(), WHOLE);
      end else if (r < 90) begin
        send_packet(good_header(), 0, TRAILER_NONE,
                    $urandom_range(1, rtpx_pkg::HEADER_BYTES - 1));
      end else begin
        send_packet(random_header(), $urandom_range(0, 40), TRAILER_NONE, WHOLE);
      end
      // now and then stop offering until the core has emptied
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  // Result side: random ready with calm stretches, plus one long hold-off
  // on request, counted here so the sender keeps offering meanwhile.
  initial begin : receiver
    int unsigned stall;
    int unsigned mode_left;
    logic        calm;
    stall          = 0;
    mode_left      = 0;
    calm           = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (choke_served != choke_asked) begin
        out_chan.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_served++;
        out_chan.ready <= 1'b1;
      end else if (stall != 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap(calm);
        if (stall != 0) begin
          out_chan.ready <= 1'b0;
          stall--;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned ph;
    in_chan.valid     = 1'b0;
    in_chan.data_byte = '0;
    in_chan.last      = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_profile(16'hFFFF);
    run_directed();

    // walk the profile through zero and random values; choke the result
    // side early in the first random phase so the core backs up
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_profile((ph == 0) ? 16'h0000 : 16'($urandom));
      if (ph == 0) choke_asked++;
      run_random(RANDOM_BYTES / RANDOM_PHASES, RANDOM_RESULTS / RANDOM_PHASES);
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("rtp_ext_packet_checker_crc_core test passed");
    end else begin
      $display("rtp_ext_packet_checker_crc_core test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #40_000_000;
    $display("rtp_ext_packet_checker_crc_core test failed");
    $finish;
  end

endmodule
